// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the unescaper checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define JSU_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define JSU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu check failed");

`endif

// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

    typedef enum logic [1:0] {
        STAT_DATA  = 2'd0,
        STAT_CLOSE = 2'd1,
        STAT_ERROR = 2'd2
    } status_t;

    // Result group produced by one input byte: up to four bytes.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        status_t         status;
    } grp_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;

    localparam logic [20:0] SUPPL_BASE = 21'h10000;

    // {valid, nibble}; valid low for a non-hex character.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// Escape state machine; turns one raw byte into a group of result bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_decode
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [7:0]     in_byte,
    output logic           grp_valid,
    output jsu_pkg::grp_t  grp
);

    typedef enum logic [6:0] {
        M_OPEN    = 7'b0000001,
        M_TEXT    = 7'b0000010,
        M_ESC     = 7'b0000100,
        M_HEX     = 7'b0001000,
        M_WANT_BS = 7'b0010000,
        M_WANT_U  = 7'b0100000,
        M_HEX_LOW = 7'b1000000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;      // hex digit position
    logic [7:0]  hi_reg, hi_next;        // upper byte of the code unit
    logic [3:0]  nib_reg, nib_next;      // first digit of a pair
    logic        nibok_reg, nibok_next;
    logic [9:0]  sav_reg, sav_next;      // saved high surrogate, low 10 bits

    logic [4:0]  hv;
    logic [7:0]  pair;
    logic [15:0] unit;
    logic        unit_done;
    logic [20:0] cp;

    assign hv = jsu_pkg::hex_value(in_byte);

    always_comb
    begin
        if (!nibok_reg) begin
            pair = 8'h00;
        end else if (!hv[4]) begin
            pair = {4'h0, nib_reg};
        end else begin
            pair = {nib_reg, hv[3:0]};
        end
    end

    assign unit      = {hi_reg, pair};
    assign unit_done = (cnt_reg == 2'd3);
    assign cp        = jsu_pkg::SUPPL_BASE + {1'b0, sav_reg, unit[9:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        nib_next   = nib_reg;
        nibok_next = nibok_reg;
        sav_next   = sav_reg;
        grp_valid  = 1'b0;
        grp        = '0;
        grp.status = jsu_pkg::STAT_DATA;

        if (in_fire) begin
            // digit bookkeeping shared by both hex modes
            if (mode_reg == M_HEX || mode_reg == M_HEX_LOW) begin
                if (!cnt_reg[0]) begin
                    nibok_next = hv[4];
                    nib_next   = hv[4] ? hv[3:0] : 4'h0;
                end else if (cnt_reg == 2'd1) begin
                    hi_next = pair;
                end
                cnt_next = cnt_reg + 2'd1;
            end

            case (mode_reg)
                M_ESC:
                begin
                    mode_next    = M_TEXT;
                    grp_valid    = 1'b1;
                    grp.data[0]  = in_byte;
                    case (in_byte)
                        jsu_pkg::CH_B: grp.data[0] = 8'h08;
                        jsu_pkg::CH_F: grp.data[0] = 8'h0C;
                        jsu_pkg::CH_N: grp.data[0] = 8'h0A;
                        jsu_pkg::CH_R: grp.data[0] = 8'h0D;
                        jsu_pkg::CH_T: grp.data[0] = 8'h09;
                        jsu_pkg::CH_U:
                        begin
                            grp_valid  = 1'b0;
                            mode_next  = M_HEX;
                            cnt_next   = 2'd0;
                            hi_next    = 8'h00;
                            nib_next   = 4'h0;
                            nibok_next = 1'b0;
                        end
                        default: grp.data[0] = in_byte;
                    endcase
                end
                M_HEX:
                begin
                    if (unit_done) begin
                        mode_next = M_TEXT;
                        if (unit == 16'h0000 ||
                            unit inside {[jsu_pkg::LOW_SURR_MIN:jsu_pkg::LOW_SURR_MAX]}) begin
                            grp_valid = 1'b0;
                        end else if (unit inside
                                     {[jsu_pkg::HIGH_SURR_MIN:jsu_pkg::HIGH_SURR_MAX]}) begin
                            sav_next  = unit[9:0];
                            mode_next = M_WANT_BS;
                        end else if (unit < 16'h0080) begin
                            grp_valid    = 1'b1;
                            grp.data[0]  = unit[7:0];
                            grp.last_idx = 2'd0;
                        end else if (unit < 16'h0800) begin
                            grp_valid    = 1'b1;
                            grp.data[0]  = {3'b110, unit[10:6]};
                            grp.data[1]  = {2'b10, unit[5:0]};
                            grp.last_idx = 2'd1;
                        end else begin
                            grp_valid    = 1'b1;
                            grp.data[0]  = {4'b1110, unit[15:12]};
                            grp.data[1]  = {2'b10, unit[11:6]};
                            grp.data[2]  = {2'b10, unit[5:0]};
                            grp.last_idx = 2'd2;
                        end
                    end
                end
                M_WANT_BS:
                begin
                    if (in_byte == jsu_pkg::CH_BSLASH) begin
                        mode_next = M_WANT_U;
                    end else begin
                        mode_next  = M_OPEN;
                        grp_valid  = 1'b1;
                        grp.status = jsu_pkg::STAT_ERROR;
                    end
                end
                M_WANT_U:
                begin
                    if (in_byte == jsu_pkg::CH_U) begin
                        mode_next  = M_HEX_LOW;
                        cnt_next   = 2'd0;
                        hi_next    = 8'h00;
                        nib_next   = 4'h0;
                        nibok_next = 1'b0;
                    end else begin
                        mode_next  = M_OPEN;
                        grp_valid  = 1'b1;
                        grp.status = jsu_pkg::STAT_ERROR;
                    end
                end
                M_HEX_LOW:
                begin
                    if (unit_done) begin
                        grp_valid = 1'b1;
                        if (unit inside {[jsu_pkg::LOW_SURR_MIN:jsu_pkg::LOW_SURR_MAX]}) begin
                            mode_next    = M_TEXT;
                            grp.data[0]  = {5'b11110, cp[20:18]};
                            grp.data[1]  = {2'b10, cp[17:12]};
                            grp.data[2]  = {2'b10, cp[11:6]};
                            grp.data[3]  = {2'b10, cp[5:0]};
                            grp.last_idx = 2'd3;
                        end else begin
                            mode_next  = M_OPEN;
                            grp.status = jsu_pkg::STAT_ERROR;
                        end
                    end
                end
                default:
                begin
                    // open and text share the plain-character handling
                    if (mode_reg == M_OPEN && in_byte == jsu_pkg::CH_QUOTE) begin
                        mode_next = M_TEXT;
                    end else if (in_byte == jsu_pkg::CH_BSLASH) begin
                        mode_next = M_ESC;
                    end else if (in_byte == jsu_pkg::CH_QUOTE) begin
                        mode_next  = M_OPEN;
                        grp_valid  = 1'b1;
                        grp.status = jsu_pkg::STAT_CLOSE;
                    end else begin
                        mode_next   = M_TEXT;
                        grp_valid   = 1'b1;
                        grp.data[0] = in_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_OPEN;
            cnt_reg   <= 2'd0;
            hi_reg    <= 8'h00;
            nib_reg   <= 4'h0;
            nibok_reg <= 1'b0;
            sav_reg   <= 10'd0;
        end else begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            hi_reg    <= hi_next;
            nib_reg   <= nib_next;
            nibok_reg <= nibok_next;
            sav_reg   <= sav_next;
        end
    end

endmodule

// ===== rtl/core/jsu_emit.sv =====
// ----------------------------------------------------------------------------
// jsu_emit
// Result register; hands a group out one byte per output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_emit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jsu_pkg::grp_t     grp,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output jsu_pkg::status_t  status,
    output logic              last
);

    logic          valid_reg;
    jsu_pkg::grp_t grp_reg;
    logic [1:0]    idx_reg;
    logic          take;
    logic          done;

    assign take      = valid_reg && !out_stall;
    assign done      = take && (idx_reg == grp_reg.last_idx);
    assign room      = !valid_reg || done;
    assign out_valid = valid_reg;
    assign out_byte  = grp_reg.data[idx_reg];
    assign status    = grp_reg.status;
    assign last      = (idx_reg == grp_reg.last_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (done) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            grp_reg <= grp;
        end
    end

endmodule

// ===== rtl/core/json_string_unescaper_core.sv =====
// ----------------------------------------------------------------------------
// json_string_unescaper_core
// Latency: the first result of a byte is shown on the cycle after its accept.
// Throughput: one input byte per cycle if out_stall is low and each byte yields
// at most one result; a byte with n results (up to four) takes n transactions.
// Reset (rst_n, async, low): output empty, parser expects an opening quote.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_unescaper_core
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       last
);

    // The decoder holds the escape/hex state and maps the incoming byte
    // straight into a result group. The emitter registers the group and
    // serializes it. A new byte is taken whenever the emitter is empty or
    // its final byte leaves this cycle, so single-result traffic streams
    // at one transaction per cycle while out_stall is low.

    logic              in_fire;
    logic              room;
    logic              grp_valid;
    jsu_pkg::grp_t     grp;
    jsu_pkg::status_t  status_e;

    assign in_stall = !room;
    assign in_fire  = in_valid && room;

    jsu_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (in_byte),
        .grp_valid (grp_valid),
        .grp       (grp)
    );

    // Bytes that only move the escape state (backslash, hex digits, the
    // opening quote) leave the emitter untouched.
    jsu_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire && grp_valid),
        .grp       (grp),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .status    (status_e),
        .last      (last)
    );

    assign status = status_e;

endmodule

// ===== rtl/core/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_stall,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic [1:0] status,
    input  logic       last
);

    // close and error transactions end their group and carry a zero byte
    `JSU_ASSERT_NOW(a_ctrl_last, clk, rst_n, out_valid && status != jsu_pkg::STAT_DATA, last)
    `JSU_ASSERT_NOW(a_ctrl_zero, clk, rst_n, out_valid && status != jsu_pkg::STAT_DATA, out_byte == 8'h00)

    // mid-group the input side must be held off
    `JSU_ASSERT_NOW(a_mid_stall, clk, rst_n, out_valid && !last, in_stall)

    // a stalled result holds
    `JSU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(status) && $stable(last))

endmodule

bind json_string_unescaper_core jsu_checker u_jsu_checker (.*);

// ===== tb/sv/json_string_unescaper_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper_core_test
// Self-checking bench for the JSON string unescaper. A short directed table
// covers escapes, byte extremes, a broken surrogate pair, the close and a
// string without an opening quote. Random JSON strings follow: mostly well
// formed (plain text, simple escapes, \u units, surrogate pairs), with some
// broken pairs, bad hex digits and stray bytes mixed in. An in-bench decoder
// predicts every output transaction. Both channels idle and stall at random,
// and once the sink holds off long enough to back the core up.
// ----------------------------------------------------------------------------

module json_string_unescaper_core_test;

    localparam int unsigned HOLD_CYCLES    = 80;    // long sink hold-off
    localparam int unsigned RANDOM_BYTES   = 250;
    localparam int unsigned DRAIN_CYCLES   = 12;    // settle time after last result
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_FF  = 8'h0C;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_CR  = 8'h0D;
    localparam logic [7:0] CTRL_TAB = 8'h09;

    // Decoder state, own encoding.
    typedef enum logic [2:0] {
        P_OPEN,      // waiting for an opening quote
        P_TEXT,      // inside the string
        P_ESC,       // after a backslash
        P_HEX,       // digits of a \u unit
        P_WANT_BS,   // high surrogate seen, need backslash
        P_WANT_U,    // need 'u' of the low unit
        P_HEX_LOW    // digits of the low unit
    } parse_state_t;

    // One output transaction.
    typedef struct packed {
        logic [7:0]       data;
        jsu_pkg::status_t stat;
        logic             fin;
    } utf8_result_t;

    // One directed row: the byte, and a typed-in single result when 'typed'.
    typedef struct packed {
        logic [7:0]       b;
        logic             typed;
        logic [7:0]       eb;
        jsu_pkg::status_t es;
    } dir_row_t;

    typedef struct {
        logic [7:0]       b;
        bit               typed;
        logic [7:0]       eb;
        jsu_pkg::status_t es;
        bit               calm;    // no idling on either side while this byte goes
    } stim_t;

    localparam int unsigned N_DIRECTED = 25;

    localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
        '{jsu_pkg::CH_QUOTE,  1'b0, 8'h00, jsu_pkg::STAT_DATA},   // opening quote is dropped
        '{8'h00,              1'b1, 8'h00, jsu_pkg::STAT_DATA},   // lowest raw byte
        '{8'hFF,              1'b1, 8'hFF, jsu_pkg::STAT_DATA},   // highest raw byte
        '{jsu_pkg::CH_BSLASH, 1'b0, 8'h00, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_B,      1'b1, 8'h08, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_BSLASH, 1'b0, 8'h00, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_F,      1'b1, 8'h0C, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_BSLASH, 1'b0, 8'h00, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_N,      1'b1, 8'h0A, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_BSLASH, 1'b0, 8'h00, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_R,      1'b1, 8'h0D, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_BSLASH, 1'b0, 8'h00, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_T,      1'b1, 8'h09, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_BSLASH, 1'b0, 8'h00, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_QUOTE,  1'b1, 8'h22, jsu_pkg::STAT_DATA},   // escaped quote passes
        '{jsu_pkg::CH_BSLASH, 1'b0, 8'h00, jsu_pkg::STAT_DATA},
        '{jsu_pkg::CH_U,      1'b0, 8'h00, jsu_pkg::STAT_DATA},
        '{8'h44,              1'b0, 8'h00, jsu_pkg::STAT_DATA},   // D
        '{8'h38,              1'b0, 8'h00, jsu_pkg::STAT_DATA},   // 8
        '{8'h30,              1'b0, 8'h00, jsu_pkg::STAT_DATA},   // 0
        '{8'h30,              1'b0, 8'h00, jsu_pkg::STAT_DATA},   // 0: high surrogate
        '{8'h41,              1'b1, 8'h00, jsu_pkg::STAT_ERROR},  // not a backslash
        '{8'h42,              1'b1, 8'h42, jsu_pkg::STAT_DATA},   // no opening quote
        '{jsu_pkg::CH_QUOTE,  1'b1, 8'h00, jsu_pkg::STAT_CLOSE},  // bare quote closes
        '{8'h5A,              1'b1, 8'h5A, jsu_pkg::STAT_DATA}    // byte after close
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    json_string_unescaper_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    stim_t        stim_q [$];
    utf8_result_t decoded_q [$];     // results still owed by the core
    utf8_result_t step_results [$];  // results of the byte being decoded

    int unsigned  mismatch_count = 0;
    int unsigned  accepted_count = 0;
    int unsigned  idle_cycles    = 0;
    int unsigned  hold_at;
    bit           hold_request   = 1'b0;
    bit           hold_done      = 1'b0;
    bit           calm_now       = 1'b0;
    bit           gen_calm       = 1'b0;

    // Decoder copy of the core's state.
    parse_state_t mode;
    logic [1:0]   hex_cnt;
    logic [15:0]  hex_acc;
    logic [15:0]  high_save;
    logic [3:0]   nib;
    logic         nib_ok;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Decoder (predictor)
    // ------------------------------------------------------------------------
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
        if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h61 + 8'd10)};
        if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h41 + 8'd10)};
        return 5'h00;
    endfunction

    function automatic void emit(input logic [7:0] d, input jsu_pkg::status_t s);
        utf8_result_t r;
        r.data = d;
        r.stat = s;
        r.fin  = 1'b0;
        step_results = {step_results, r};
    endfunction

    function automatic void begin_unit(input parse_state_t next_mode);
        mode    = next_mode;
        hex_cnt = 2'd0;
        hex_acc = 16'h0000;
        nib     = 4'h0;
        nib_ok  = 1'b0;
    endfunction

    // Digits pair up; a non-hex first digit zeroes the pair, a non-hex
    // second digit leaves the first digit alone as the pair value.
    function automatic bit take_hex_digit(input logic [7:0] b);
        logic [4:0] h;
        logic [7:0] pair;
        logic [1:0] d;
        h = nibble_of(b);
        d = hex_cnt;
        if (!d[0])
        begin
            nib_ok = h[4];
            nib    = h[4] ? h[3:0] : 4'h0;
        end
        else
        begin
            if (!nib_ok)     pair = 8'h00;
            else if (!h[4])  pair = {4'h0, nib};
            else             pair = {nib, h[3:0]};
            if (d == 2'd1) hex_acc = {pair, 8'h00};
            else           hex_acc = hex_acc | {8'h00, pair};
        end
        hex_cnt = d + 2'd1;
        return d == 2'd3;
    endfunction

    function automatic void text_byte(input logic [7:0] b);
        if (b == jsu_pkg::CH_BSLASH)
            mode = P_ESC;
        else if (b == jsu_pkg::CH_QUOTE)
        begin
            emit(8'h00, jsu_pkg::STAT_CLOSE);
            mode = P_OPEN;
        end
        else
        begin
            emit(b, jsu_pkg::STAT_DATA);
            mode = P_TEXT;
        end
    endfunction

    function automatic void abandon_string();
        mode = P_OPEN;
        emit(8'h00, jsu_pkg::STAT_ERROR);
    endfunction

    // Decodes one raw byte into step_results and advances the state.
    function automatic void unescape_byte(input logic [7:0] b);
        logic [15:0] c;
        logic [20:0] cp;
        step_results.delete();
        case (mode)
            P_TEXT: text_byte(b);
            P_ESC:
            begin
                mode = P_TEXT;
                case (b)
                    jsu_pkg::CH_B: emit(CTRL_BS, jsu_pkg::STAT_DATA);
                    jsu_pkg::CH_F: emit(CTRL_FF, jsu_pkg::STAT_DATA);
                    jsu_pkg::CH_N: emit(CTRL_LF, jsu_pkg::STAT_DATA);
                    jsu_pkg::CH_R: emit(CTRL_CR, jsu_pkg::STAT_DATA);
                    jsu_pkg::CH_T: emit(CTRL_TAB, jsu_pkg::STAT_DATA);
                    jsu_pkg::CH_U: begin_unit(P_HEX);
                    default:       emit(b, jsu_pkg::STAT_DATA);
                endcase
            end
            P_HEX:
            begin
                if (take_hex_digit(b))
                begin
                    c    = hex_acc;
                    mode = P_TEXT;
                    // NUL and a lone low surrogate give nothing
                    if (c != 16'h0000 &&
                        !(c >= jsu_pkg::LOW_SURR_MIN && c <= jsu_pkg::LOW_SURR_MAX))
                    begin
                        if (c >= jsu_pkg::HIGH_SURR_MIN && c <= jsu_pkg::HIGH_SURR_MAX)
                        begin
                            high_save = c;
                            mode      = P_WANT_BS;
                        end
                        else if (c < 16'h0080)
                            emit(c[7:0], jsu_pkg::STAT_DATA);
                        else if (c < 16'h0800)
                        begin
                            emit({3'b110, c[10:6]}, jsu_pkg::STAT_DATA);
                            emit({2'b10, c[5:0]}, jsu_pkg::STAT_DATA);
                        end
                        else
                        begin
                            emit({4'b1110, c[15:12]}, jsu_pkg::STAT_DATA);
                            emit({2'b10, c[11:6]}, jsu_pkg::STAT_DATA);
                            emit({2'b10, c[5:0]}, jsu_pkg::STAT_DATA);
                        end
                    end
                end
            end
            P_WANT_BS:
            begin
                if (b == jsu_pkg::CH_BSLASH) mode = P_WANT_U;
                else                         abandon_string();
            end
            P_WANT_U:
            begin
                if (b == jsu_pkg::CH_U) begin_unit(P_HEX_LOW);
                else                    abandon_string();
            end
            P_HEX_LOW:
            begin
                if (take_hex_digit(b))
                begin
                    c = hex_acc;
                    if (c >= jsu_pkg::LOW_SURR_MIN && c <= jsu_pkg::LOW_SURR_MAX)
                    begin
                        cp = jsu_pkg::SUPPL_BASE
                             + (21'(high_save - jsu_pkg::HIGH_SURR_MIN) << 10)
                             + 21'(c - jsu_pkg::LOW_SURR_MIN);
                        emit({5'b11110, cp[20:18]}, jsu_pkg::STAT_DATA);
                        emit({2'b10, cp[17:12]}, jsu_pkg::STAT_DATA);
                        emit({2'b10, cp[11:6]}, jsu_pkg::STAT_DATA);
                        emit({2'b10, cp[5:0]}, jsu_pkg::STAT_DATA);
                        mode = P_TEXT;
                    end
                    else
                        abandon_string();
                end
            end
            default:
            begin
                if (b == jsu_pkg::CH_QUOTE) mode = P_TEXT;
                else                        text_byte(b);
            end
        endcase
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].fin = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b);
        stim_t s;
        s.b     = b;
        s.typed = 1'b0;
        s.eb    = 8'h00;
        s.es    = jsu_pkg::STAT_DATA;
        s.calm  = gen_calm;
        stim_q  = {stim_q, s};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void add_unit(input logic [15:0] v);
        add_byte(jsu_pkg::CH_BSLASH);
        add_byte(jsu_pkg::CH_U);
        for (int k = 3; k >= 0; k--)
            add_byte(hex_char(v[k*4 +: 4]));
    endfunction

    function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] z);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == a || b == z);
        return b;
    endfunction

    function automatic logic [15:0] high_surr();
        return 16'($urandom_range(jsu_pkg::HIGH_SURR_MIN, jsu_pkg::HIGH_SURR_MAX));
    endfunction

    function automatic logic [15:0] low_surr();
        return 16'($urandom_range(jsu_pkg::LOW_SURR_MIN, jsu_pkg::LOW_SURR_MAX));
    endfunction

    // One \u item: plain code units of every length, NUL, lone low halves,
    // surrogate pairs (good and broken) and digits that are not hex.
    function automatic void add_codepoint();
        logic [15:0] edges [0:6];
        edges = '{16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
        case ($urandom_range(0, 15))
            0, 1:     add_unit(16'($urandom_range(1, 16'h007F)));
            2:        add_unit(16'h0000);
            3, 4:     add_unit(16'($urandom_range(16'h0080, 16'h07FF)));
            5, 6:     add_unit($urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                                    : 16'($urandom_range(16'hE000, 16'hFFFF)));
            7:        add_unit(low_surr());
            8, 9, 10:
            begin
                add_unit(high_surr());
                add_unit(low_surr());
            end
            11:
            begin
                case ($urandom_range(0, 8))
                    7:
                    begin
                        add_unit(jsu_pkg::HIGH_SURR_MAX);
                        add_unit(jsu_pkg::LOW_SURR_MAX);
                    end
                    8:
                    begin
                        add_unit(jsu_pkg::HIGH_SURR_MIN);
                        add_unit(jsu_pkg::LOW_SURR_MIN);
                    end
                    default: add_unit(edges[$urandom_range(0, 6)]);
                endcase
            end
            12:
            begin
                add_unit(high_surr());
                add_byte(byte_except(jsu_pkg::CH_BSLASH, jsu_pkg::CH_BSLASH));
            end
            13:
            begin
                add_unit(high_surr());
                add_byte(jsu_pkg::CH_BSLASH);
                add_byte(byte_except(jsu_pkg::CH_U, jsu_pkg::CH_U));
            end
            14:
            begin
                add_unit(high_surr());
                add_unit($urandom_range(0, 1) ? 16'($urandom_range(0, 16'hDBFF))
                                              : 16'($urandom_range(16'hE000, 16'hFFFF)));
            end
            default:
            begin
                // quotes and backslashes may land in digit slots
                add_byte(jsu_pkg::CH_BSLASH);
                add_byte(jsu_pkg::CH_U);
                repeat (4)
                    add_byte($urandom_range(0, 1) ? hex_char(4'($urandom_range(0, 15)))
                                                  : 8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void add_string();
        gen_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) != 0)
            add_byte(jsu_pkg::CH_QUOTE);
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 5))
                0, 1: add_byte(byte_except(jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH));
                2:
                begin
                    add_byte(jsu_pkg::CH_BSLASH);
                    case ($urandom_range(0, 8))
                        0: add_byte(jsu_pkg::CH_B);
                        1: add_byte(jsu_pkg::CH_F);
                        2: add_byte(jsu_pkg::CH_N);
                        3: add_byte(jsu_pkg::CH_R);
                        4: add_byte(jsu_pkg::CH_T);
                        5: add_byte(jsu_pkg::CH_QUOTE);
                        6: add_byte(jsu_pkg::CH_BSLASH);
                        7: add_byte(CH_SLASH);
                        default: add_byte(byte_except(jsu_pkg::CH_U, jsu_pkg::CH_U));
                    endcase
                end
                3, 4: add_codepoint();
                default: add_byte(8'($urandom_range(0, 255)));   // stray byte
            endcase
        end
        if ($urandom_range(0, 7) != 0)
            add_byte(jsu_pkg::CH_QUOTE);
    endfunction

    // Idle length: mostly none, sometimes short, now and then long.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. The prediction for a
    // byte accepted at this edge is queued before the output is checked, so
    // ordering holds whatever the core's latency.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        utf8_result_t exp;
        bit           in_fire;
        bit           out_fire;
        if (rst_n)
        begin
            in_fire  = in_valid && !in_stall;
            out_fire = out_valid && !out_stall;

            if (in_fire)
            begin
                unescape_byte(in_byte);
                if (stim_q[accepted_count].typed)
                begin
                    // directed row: the typed-in result stands in for the decoder
                    exp.data  = stim_q[accepted_count].eb;
                    exp.stat  = stim_q[accepted_count].es;
                    exp.fin   = 1'b1;
                    decoded_q = {decoded_q, exp};
                end
                else
                begin
                    decoded_q = {decoded_q, step_results};
                end
                accepted_count++;
            end

            if (out_fire)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("unexpected result byte=%02h status=%0d last=%0b",
                                              out_byte, status, last));
                else
                begin
                    exp = decoded_q.pop_front();
                    if (out_byte !== exp.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, exp.data));
                    if (status !== exp.stat)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  status, exp.stat.name()));
                    if (last !== exp.fin)
                        report_mismatch($sformatf("last %0b, expected %0b", last, exp.fin));
                end
            end

            idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: too long without any transaction means the core is hung.
    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold-off requested by the
    // source so that the core fills and pushes back on its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else
            begin
                n = pick_gap(calm_now);
                if (n != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: build stimulus, reset, drive bytes, drain, verdict.
    // ------------------------------------------------------------------------
    initial
    begin : byte_source
        stim_t       s;
        int unsigned gap;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;

        mode      = P_OPEN;
        hex_cnt   = 2'd0;
        hex_acc   = 16'h0000;
        high_save = 16'h0000;
        nib       = 4'h0;
        nib_ok    = 1'b0;

        // directed table first
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            s.b     = DIRECTED[i].b;
            s.typed = DIRECTED[i].typed;
            s.eb    = DIRECTED[i].eb;
            s.es    = DIRECTED[i].es;
            s.calm  = 1'b0;
            stim_q  = {stim_q, s};
        end
        // then random strings
        while (stim_q.size() < N_DIRECTED + RANDOM_BYTES)
            add_string();
        hold_at = N_DIRECTED + 90;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_q[i])
        begin
            if (i == hold_at)
                hold_request = 1'b1;
            calm_now = stim_q[i].calm;
            // keep offering back to back while the sink holds off
            gap = (hold_request && !hold_done) ? 0 : pick_gap(stim_q[i].calm);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= stim_q[i].b;
            do
                @(posedge clk);
            while (in_stall);
            @(negedge clk);
        end
        in_valid <= 1'b0;
        calm_now = 1'b0;

        while (decoded_q.size() != 0)
            @(posedge clk);
        // bytes that give nothing may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (decoded_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_emit.sv
rtl/core/json_string_unescaper_core.sv
rtl/core/jsu_checker.sv
tb/sv/json_string_unescaper_core_test.sv
